>>> src/ame_pkg.sv
// Shared types and constants for the accumulator machine execute core.
`timescale 1ns / 1ps

package ame_pkg;

    // Width of the operand address fields and the number of addresses they span.
    localparam int ADDR_W    = 4;
    localparam int ADDR_SPAN = 16;
    localparam int DATA_W    = 32;

    // Operation codes; codes above OP_END are ignored.
    typedef enum logic [3:0] {
        OP_SET   = 4'd0,
        OP_SHW   = 4'd1,
        OP_ADD   = 4'd2,
        OP_LDR   = 4'd3,
        OP_INC   = 4'd4,
        OP_DEC   = 4'd5,
        OP_STR   = 4'd6,
        OP_PAUSE = 4'd7,
        OP_END   = 4'd8
    } opcode_t;

    // Sources that a show operation can select.
    typedef enum logic [2:0] {
        SHOW_MEM    = 3'd0,
        SHOW_ACC    = 3'd1,
        SHOW_MAR    = 3'd2,
        SHOW_COUNT  = 3'd3,
        SHOW_MDR    = 3'd4,
        SHOW_OPCODE = 3'd5
    } show_target_t;

    // Kinds of result beat.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SHOWN  = 2'd1,
        KIND_PAUSED = 2'd2,
        KIND_HALTED = 2'd3
    } result_kind_t;

    // One decoded instruction as held in the execute register.
    typedef struct packed {
        logic [3:0]        operation;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [ADDR_W-1:0] addr_c;
        logic              has_b;
        logic              has_c;
        logic [DATA_W-1:0] immediate;
        logic [2:0]        show_target;
    } item_t;

    // Architectural registers of the machine, apart from the data memory.
    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [ADDR_W-1:0] mar;
        logic [DATA_W-1:0] mdr;
        logic [DATA_W-1:0] count;
        logic [3:0]        last_op;
        logic              halted;
    } arch_state_t;

    // Data memory write request; the address is the raw operand address.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

endpackage

>>> src/ame_dmem.sv
// Data memory with a clearing sweep after reset and two forwarded read ports.
`timescale 1ns / 1ps

module ame_dmem #(
    parameter int MEM_DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic [ame_pkg::ADDR_W-1:0]  rd_addr_a,
    input  logic [ame_pkg::ADDR_W-1:0]  rd_addr_b,
    input  ame_pkg::mem_wr_t            wr,
    output logic [ame_pkg::DATA_W-1:0]  rd_data_a,
    output logic [ame_pkg::DATA_W-1:0]  rd_data_b,
    output logic                        busy
);

    localparam int SLOT_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MEM_DEPTH + 1);

    logic [ame_pkg::DATA_W-1:0] mem [MEM_DEPTH];
    logic [SLOT_W-1:0]          slot_lut [ame_pkg::ADDR_SPAN];
    logic [CNT_W-1:0]           clr_cnt_reg;
    logic [CNT_W-1:0]           clr_cnt_next;
    logic                       we;
    logic [SLOT_W-1:0]          wa;
    logic [ame_pkg::DATA_W-1:0] wd;
    logic [SLOT_W-1:0]          sa;
    logic [SLOT_W-1:0]          sb;
    logic [SLOT_W-1:0]          sw;
    logic [ame_pkg::DATA_W-1:0] rd_a_reg;
    logic [ame_pkg::DATA_W-1:0] rd_b_reg;
    logic                       fwd_a_reg;
    logic                       fwd_b_reg;
    logic [ame_pkg::DATA_W-1:0] fwd_data_reg;

    // Operand addresses fold onto the memory depth through a constant table.
    for (genvar i = 0; i < ame_pkg::ADDR_SPAN; i++) begin : g_slot
        assign slot_lut[i] = SLOT_W'(i % MEM_DEPTH);
    end

    assign sa = slot_lut[rd_addr_a];
    assign sb = slot_lut[rd_addr_b];
    assign sw = slot_lut[wr.addr];

    // Clearing sweep: one entry per cycle after reset.
    assign busy         = (clr_cnt_reg != CNT_W'(MEM_DEPTH));
    assign clr_cnt_next = busy ? clr_cnt_reg + CNT_W'(1) : clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Write port is shared between the sweep and the execute stage.
    assign we = busy || wr.en;
    assign wa = busy ? clr_cnt_reg[SLOT_W-1:0] : sw;
    assign wd = busy ? '0 : wr.data;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    // Registered reads; a write in the same cycle to the same entry is forwarded.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg     <= mem[sa];
            rd_b_reg     <= mem[sb];
            fwd_a_reg    <= wr.en && (sw == sa);
            fwd_b_reg    <= wr.en && (sw == sb);
            fwd_data_reg <= wr.data;
        end
    end

    assign rd_data_a = fwd_a_reg ? fwd_data_reg : rd_a_reg;
    assign rd_data_b = fwd_b_reg ? fwd_data_reg : rd_b_reg;

endmodule

>>> src/ame_exec.sv
// Execute logic: next machine state, memory write and result for one instruction.
`timescale 1ns / 1ps

module ame_exec (
    input  ame_pkg::item_t              item,
    input  ame_pkg::arch_state_t        state,
    input  logic [ame_pkg::DATA_W-1:0]  mem_a,
    input  logic [ame_pkg::DATA_W-1:0]  mem_b,
    output ame_pkg::arch_state_t        state_next,
    output ame_pkg::mem_wr_t            wr,
    output ame_pkg::result_kind_t       kind,
    output logic [ame_pkg::DATA_W-1:0]  shown
);

    logic                       done;
    logic [ame_pkg::DATA_W-1:0] sum;

    // The adder of a two-operand add: sums both memory operands.
    assign sum = mem_a + mem_b;

    always_comb begin
        state_next = state;
        wr.en      = 1'b0;
        wr.addr    = item.addr_a;
        wr.data    = mem_a;
        kind       = ame_pkg::KIND_NONE;
        shown      = '0;
        done       = 1'b0;

        if (!state.halted) begin
            unique case (ame_pkg::opcode_t'(item.operation))
                ame_pkg::OP_SET: begin
                    state_next.mar = item.addr_a;
                    state_next.mdr = item.immediate;
                    wr.en          = 1'b1;
                    wr.data        = item.immediate;
                    done           = 1'b1;
                end
                ame_pkg::OP_SHW: begin
                    done = 1'b1;
                    kind = ame_pkg::KIND_SHOWN;
                    unique case (ame_pkg::show_target_t'(item.show_target))
                        ame_pkg::SHOW_MEM:    shown = mem_a;
                        ame_pkg::SHOW_ACC:    shown = state.acc;
                        ame_pkg::SHOW_MAR:    shown = ame_pkg::DATA_W'(state.mar);
                        ame_pkg::SHOW_COUNT:  shown = state.count;
                        ame_pkg::SHOW_MDR:    shown = state.mdr;
                        ame_pkg::SHOW_OPCODE: shown = ame_pkg::DATA_W'(ame_pkg::OP_SHW);
                        default: begin
                            done = 1'b0;
                            kind = ame_pkg::KIND_NONE;
                        end
                    endcase
                end
                ame_pkg::OP_ADD: begin
                    if (!item.has_b && !item.has_c) begin
                        state_next.mar = item.addr_a;
                        state_next.mdr = mem_a;
                        state_next.acc = state.acc + mem_a;
                        done           = 1'b1;
                    end else if (item.has_b) begin
                        state_next.mar = item.addr_b;
                        state_next.mdr = mem_b;
                        done           = 1'b1;
                        if (item.has_c) begin
                            wr.en   = 1'b1;
                            wr.addr = item.addr_c;
                            wr.data = sum;
                        end else begin
                            state_next.acc = sum;
                        end
                    end
                end
                ame_pkg::OP_LDR: begin
                    state_next.mar = item.addr_a;
                    state_next.mdr = mem_a;
                    state_next.acc = mem_a;
                    done           = 1'b1;
                end
                ame_pkg::OP_INC: begin
                    state_next.mar = item.addr_a;
                    state_next.mdr = mem_a;
                    wr.en          = 1'b1;
                    wr.data        = mem_a + ame_pkg::DATA_W'(1);
                    done           = 1'b1;
                end
                ame_pkg::OP_DEC: begin
                    state_next.mar = item.addr_a;
                    state_next.mdr = mem_a;
                    wr.en          = 1'b1;
                    wr.data        = mem_a - ame_pkg::DATA_W'(1);
                    done           = 1'b1;
                end
                ame_pkg::OP_STR: begin
                    state_next.mar = item.addr_a;
                    state_next.acc = '0;
                    wr.en          = 1'b1;
                    wr.data        = state.acc;
                    done           = 1'b1;
                end
                ame_pkg::OP_PAUSE: begin
                    kind = ame_pkg::KIND_PAUSED;
                    done = 1'b1;
                end
                ame_pkg::OP_END: begin
                    state_next.last_op = item.operation;
                    state_next.halted  = 1'b1;
                    kind               = ame_pkg::KIND_HALTED;
                end
                default: begin
                    // Undefined operation codes leave the machine untouched.
                end
            endcase
        end

        // Every completed instruction other than END is counted.
        if (done) begin
            state_next.last_op = item.operation;
            state_next.count   = state.count + ame_pkg::DATA_W'(1);
        end
    end

endmodule

>>> src/accumulator_machine_execute_core.sv
// Top level of the accumulator machine execute core.
// Each instruction passes the execute register, then its result beat the output register.
// Throughput: one instruction per cycle; s_ready drops while clearing or m_ready holds off.
// Reset: synchronous, active low; control and machine state registers return to zero.
// After reset the data memory is cleared one entry per cycle,
// with s_ready held low until the sweep completes.
`timescale 1ns / 1ps

module accumulator_machine_execute_core #(
    parameter int MEM_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_operation,
    input  logic [3:0]         s_addr_a,
    input  logic [3:0]         s_addr_b,
    input  logic [3:0]         s_addr_c,
    input  logic               s_has_b,
    input  logic               s_has_c,
    input  logic signed [31:0] s_immediate,
    input  logic [2:0]         s_show_target,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_kind,
    output logic signed [31:0] m_shown_value
);

    logic                         accept;
    logic                         adv;
    logic                         busy;
    logic                         ex_valid_reg;
    logic                         ex_valid_next;
    ame_pkg::item_t               item_reg;
    ame_pkg::arch_state_t         state_reg;
    ame_pkg::arch_state_t         state_next;
    ame_pkg::mem_wr_t             ex_wr;
    ame_pkg::mem_wr_t             mem_wr;
    ame_pkg::result_kind_t        ex_kind;
    logic [ame_pkg::DATA_W-1:0]   ex_shown;
    logic [ame_pkg::DATA_W-1:0]   mem_a;
    logic [ame_pkg::DATA_W-1:0]   mem_b;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [1:0]                   m_kind_reg;
    logic [ame_pkg::DATA_W-1:0]   m_shown_reg;

    // Handshake: the execute register drains into the output register.
    assign adv     = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !busy && (!ex_valid_reg || adv);
    assign accept  = s_valid && s_ready;

    // Memory writes only take effect when the instruction retires.
    always_comb begin
        mem_wr    = ex_wr;
        mem_wr.en = ex_wr.en && adv;
    end

    ame_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (s_addr_a),
        .rd_addr_b (s_addr_b),
        .wr        (mem_wr),
        .rd_data_a (mem_a),
        .rd_data_b (mem_b),
        .busy      (busy)
    );

    ame_exec u_exec (
        .item       (item_reg),
        .state      (state_reg),
        .mem_a      (mem_a),
        .mem_b      (mem_b),
        .state_next (state_next),
        .wr         (ex_wr),
        .kind       (ex_kind),
        .shown      (ex_shown)
    );

    // Execute register valid.
    always_comb begin
        priority if (accept) begin
            ex_valid_next = 1'b1;
        end else if (adv) begin
            ex_valid_next = 1'b0;
        end else begin
            ex_valid_next = ex_valid_reg;
        end
    end

    // Output register valid.
    always_comb begin
        priority if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            ex_valid_reg <= ex_valid_next;
            m_valid_reg  <= m_valid_next;
            if (adv) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers for the incoming beat and the result beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.operation   <= s_operation;
            item_reg.addr_a      <= s_addr_a;
            item_reg.addr_b      <= s_addr_b;
            item_reg.addr_c      <= s_addr_c;
            item_reg.has_b       <= s_has_b;
            item_reg.has_c       <= s_has_c;
            item_reg.immediate   <= s_immediate;
            item_reg.show_target <= s_show_target;
        end
        if (adv) begin
            m_kind_reg  <= ex_kind;
            m_shown_reg <= ex_shown;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_shown_value = m_shown_reg;

    // No instruction enters while the memory is being cleared.
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready)
        else $error("instruction accepted during memory clear");

    // Machine state only moves when an instruction retires.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(state_reg))
        else $error("machine state changed without a retiring instruction");

    // Once halted, every retiring instruction produces an empty result.
    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && state_reg.halted) |=>
            (m_result_kind == ame_pkg::KIND_NONE && m_shown_value == '0))
        else $error("result produced after halt");

    // Only a shown result carries a nonzero value.
    a_value_only_when_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != ame_pkg::KIND_SHOWN) |-> m_shown_value == '0)
        else $error("nonzero value on a result that shows nothing");

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the accumulator machine execute core.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS = 1650;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 80;

    // One predicted result beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
    } outcome_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_operation   = '0;
    logic [3:0]         s_addr_a      = '0;
    logic [3:0]         s_addr_b      = '0;
    logic [3:0]         s_addr_c      = '0;
    logic               s_has_b       = 1'b0;
    logic               s_has_c       = 1'b0;
    logic signed [31:0] s_immediate   = '0;
    logic [2:0]         s_show_target = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_result_kind;
    logic signed [31:0] m_shown_value;

    // Instructions still to issue, and result beats still to arrive.
    ame_pkg::item_t program_q[$];
    outcome_t       awaited_q[$];

    int total_items = 0;
    int accepted_in = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    // Handshake and idling control.
    logic in_fire    = 1'b0;
    logic quiet      = 1'b0;
    int   gap_left   = 0;
    int   send_pct   = 15;
    int   stall_left = 0;
    int   recv_pct   = 15;
    int   hold_left  = 0;
    int   holds_done = 0;

    // Machine state as the checker sees it.
    logic [31:0] acc_s;
    logic [31:0] mem_s [ame_pkg::ADDR_SPAN];
    logic [3:0]  mar_s;
    logic [31:0] mdr_s;
    logic [31:0] icount_s;
    logic [3:0]  lastop_s;
    logic        halted_s;

    accumulator_machine_execute_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_addr_a      (s_addr_a),
        .s_addr_b      (s_addr_b),
        .s_addr_c      (s_addr_c),
        .s_has_b       (s_has_b),
        .s_has_c       (s_has_c),
        .s_immediate   (s_immediate),
        .s_show_target (s_show_target),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_shown_value (m_shown_value)
    );

    always #2 aclk = ~aclk;

    // Execute one instruction on the checker's copy of the machine.
    function automatic outcome_t exec_instruction(ame_pkg::item_t it);
        outcome_t res;
        logic     counted;
        logic [31:0] first_word;
        logic [31:0] second_word;
        res     = '{kind: ame_pkg::KIND_NONE, value: '0};
        counted = 1'b1;
        if (halted_s || it.operation > ame_pkg::OP_END) begin
            return res;
        end
        case (it.operation)
            ame_pkg::OP_SET: begin
                mar_s             = it.addr_a;
                mdr_s             = it.immediate;
                mem_s[it.addr_a]  = it.immediate;
            end
            ame_pkg::OP_SHW: begin
                if (it.show_target > ame_pkg::SHOW_OPCODE) begin
                    counted = 1'b0;
                end else begin
                    lastop_s = ame_pkg::OP_SHW;
                    res.kind = ame_pkg::KIND_SHOWN;
                    case (it.show_target)
                        ame_pkg::SHOW_MEM:   res.value = mem_s[it.addr_a];
                        ame_pkg::SHOW_ACC:   res.value = acc_s;
                        ame_pkg::SHOW_MAR:   res.value = {28'd0, mar_s};
                        ame_pkg::SHOW_COUNT: res.value = icount_s;
                        ame_pkg::SHOW_MDR:   res.value = mdr_s;
                        default:             res.value = {28'd0, lastop_s};
                    endcase
                end
            end
            ame_pkg::OP_ADD: begin
                if (!it.has_b && it.has_c) begin
                    counted = 1'b0;
                end else if (!it.has_b) begin
                    mar_s = it.addr_a;
                    mdr_s = mem_s[it.addr_a];
                    acc_s = acc_s + mdr_s;
                end else begin
                    first_word  = mem_s[it.addr_a];
                    second_word = mem_s[it.addr_b];
                    mar_s       = it.addr_b;
                    mdr_s       = second_word;
                    if (it.has_c) begin
                        mem_s[it.addr_c] = first_word + second_word;
                    end else begin
                        acc_s = first_word + second_word;
                    end
                end
            end
            ame_pkg::OP_LDR: begin
                mar_s = it.addr_a;
                mdr_s = mem_s[it.addr_a];
                acc_s = mdr_s;
            end
            ame_pkg::OP_INC, ame_pkg::OP_DEC: begin
                mar_s = it.addr_a;
                mdr_s = mem_s[it.addr_a];
                if (it.operation == ame_pkg::OP_INC) begin
                    mem_s[it.addr_a] = mdr_s + 32'd1;
                end else begin
                    mem_s[it.addr_a] = mdr_s - 32'd1;
                end
            end
            ame_pkg::OP_STR: begin
                mar_s            = it.addr_a;
                mem_s[it.addr_a] = acc_s;
                acc_s            = '0;
            end
            ame_pkg::OP_PAUSE: begin
                res.kind = ame_pkg::KIND_PAUSED;
            end
            default: begin
                // Halt: the count stays where it was.
                lastop_s = ame_pkg::OP_END;
                halted_s = 1'b1;
                res.kind = ame_pkg::KIND_HALTED;
                return res;
            end
        endcase
        if (counted) begin
            lastop_s = it.operation;
            icount_s = icount_s + 32'd1;
        end
        return res;
    endfunction

    // Random instruction with mostly legal, well-formed content and no halt.
    function automatic ame_pkg::item_t random_instr();
        ame_pkg::item_t it;
        it.addr_a = 4'($urandom_range(0, 15));
        it.addr_b = 4'($urandom_range(0, 15));
        it.addr_c = 4'($urandom_range(0, 15));
        it.has_b  = 1'($urandom_range(0, 1));
        it.has_c  = 1'($urandom_range(0, 1));
        it.show_target = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 5))
                                                      : 3'($urandom_range(6, 7));
        case ($urandom_range(0, 3))
            0: it.immediate = $urandom;
            1: it.immediate = $urandom_range(0, 20);
            2: it.immediate = -32'($urandom_range(1, 20));
            default: begin
                case ($urandom_range(0, 3))
                    0: it.immediate = 32'h7FFF_FFFF;
                    1: it.immediate = 32'h8000_0000;
                    2: it.immediate = 32'hFFFF_FFFF;
                    default: it.immediate = '0;
                endcase
            end
        endcase
        case ($urandom_range(0, 31))
            0, 1, 2, 3, 4, 5:    it.operation = ame_pkg::OP_SET;
            6, 7, 8, 9, 10:      it.operation = ame_pkg::OP_SHW;
            11, 12, 13, 14, 15:  it.operation = ame_pkg::OP_ADD;
            16, 17, 18:          it.operation = ame_pkg::OP_LDR;
            19, 20, 21:          it.operation = ame_pkg::OP_INC;
            22, 23, 24:          it.operation = ame_pkg::OP_DEC;
            25, 26, 27:          it.operation = ame_pkg::OP_STR;
            28, 29:              it.operation = ame_pkg::OP_PAUSE;
            default:             it.operation = 4'($urandom_range(ame_pkg::OP_END + 1, 15));
        endcase
        return it;
    endfunction

    task automatic add_instr(input logic [3:0] op, input logic [3:0] a, input logic [3:0] b,
                             input logic [3:0] c, input logic hb, input logic hc,
                             input logic [31:0] imm, input logic [2:0] tgt);
        ame_pkg::item_t it;
        it = '{operation: op, addr_a: a, addr_b: b, addr_c: c, has_b: hb, has_c: hc,
               immediate: imm, show_target: tgt};
        program_q = {program_q, it};
    endtask

    // Stimulus, reset and end of run.
    initial begin
        acc_s    = '0;
        mar_s    = '0;
        mdr_s    = '0;
        icount_s = '0;
        lastop_s = '0;
        halted_s = 1'b0;
        for (int i = 0; i < ame_pkg::ADDR_SPAN; i++) begin
            mem_s[i] = '0;
        end

        // Directed part: cleared memory, extreme values with wrapping sums,
        // all forms of ADD, every show source and the ignored codes.
        add_instr(ame_pkg::OP_SHW, 4'd7, 4'd0, 4'd15, 1'b1, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_SET, 4'd15, 4'd0, 4'd0, 1'b0, 1'b0, 32'h7FFF_FFFF,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_SET, 4'd0, 4'd15, 4'd15, 1'b1, 1'b1, 32'h8000_0000,
                  ame_pkg::SHOW_OPCODE);
        add_instr(ame_pkg::OP_SET, 4'd1, 4'd0, 4'd0, 1'b0, 1'b0, 32'hFFFF_FFFF,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_ADD, 4'd15, 4'd1, 4'd2, 1'b1, 1'b1, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_ADD, 4'd15, 4'd15, 4'd0, 1'b1, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_ADD, 4'd1, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_ADD, 4'd2, 4'd0, 4'd9, 1'b0, 1'b1, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_LDR, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_INC, 4'd15, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_DEC, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_INC, 4'd1, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_DEC, 4'd3, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_STR, 4'd4, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_PAUSE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_SHW, 4'd15, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_SHW, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_ACC);
        add_instr(ame_pkg::OP_SHW, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MAR);
        add_instr(ame_pkg::OP_SHW, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_COUNT);
        add_instr(ame_pkg::OP_SHW, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MDR);
        add_instr(ame_pkg::OP_SHW, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_OPCODE);
        add_instr(ame_pkg::OP_SHW, 4'd4, 4'd0, 4'd0, 1'b0, 1'b0, $urandom, 3'd6);
        add_instr(ame_pkg::OP_SHW, 4'd4, 4'd0, 4'd0, 1'b0, 1'b0, $urandom, 3'd7);
        add_instr(4'd9, 4'd0, 4'd0, 4'd0, 1'b1, 1'b1, $urandom, ame_pkg::SHOW_MEM);
        add_instr(4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1, $urandom, 3'd7);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            program_q = {program_q, random_instr()};
        end

        // Halt last, followed by items that must be ignored.
        add_instr(ame_pkg::OP_END, 4'($urandom), 4'($urandom), 4'($urandom), 1'b0, 1'b0,
                  $urandom, ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_SHW, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_COUNT);
        add_instr(ame_pkg::OP_SET, 4'd5, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        add_instr(ame_pkg::OP_END, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, $urandom,
                  ame_pkg::SHOW_MEM);
        for (int i = 0; i < 8; i++) begin
            program_q = {program_q, random_instr()};
        end
        total_items = program_q.size();

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        while (accepted_in < total_items || awaited_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Sender: offers the next instruction once the current beat is taken.
    always @(negedge aclk) begin : drive_instr
        ame_pkg::item_t it;
        quiet <= (program_q.size() < QUIET_TAIL);
        if ($urandom_range(0, 299) == 0) begin
            send_pct <= $urandom_range(0, 2) * 20;
        end
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (program_q.size() != 0) begin
                it = program_q.pop_front();
                s_operation   <= it.operation;
                s_addr_a      <= it.addr_a;
                s_addr_b      <= it.addr_b;
                s_addr_c      <= it.addr_c;
                s_has_b       <= it.has_b;
                s_has_c       <= it.has_c;
                s_immediate   <= it.immediate;
                s_show_target <= it.show_target;
                s_valid       <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < send_pct) begin
                    gap_left <= $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus the long hold-off.
    always @(negedge aclk) begin
        if ($urandom_range(0, 299) == 0) begin
            recv_pct <= $urandom_range(0, 2) * 20;
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (aresetn && !quiet && $urandom_range(0, 99) < recv_pct) begin
            stall_left <= $urandom_range(0, 5);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Long hold-off on the result side so the core backs up into its input.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && accepted_in >= 300) ||
                     (holds_done == 1 && accepted_in >= 1100)) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Monitor: predicts each accepted instruction and checks each result beat.
    always @(posedge aclk) begin : observe
        ame_pkg::item_t cur;
        outcome_t       pred;
        outcome_t       want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                cur.operation   = s_operation;
                cur.addr_a      = s_addr_a;
                cur.addr_b      = s_addr_b;
                cur.addr_c      = s_addr_c;
                cur.has_b       = s_has_b;
                cur.has_c       = s_has_c;
                cur.immediate   = s_immediate;
                cur.show_target = s_show_target;
                pred            = exec_instruction(cur);
                awaited_q       = {awaited_q, pred};
                accepted_in <= accepted_in + 1;
            end
            if (m_valid && m_ready) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t: unexpected result beat, kind %0d value %h",
                             $realtime, m_result_kind, m_shown_value);
                    fail_count++;
                end else begin
                    want = awaited_q.pop_front();
                    if (m_result_kind !== want.kind) begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $realtime, want.kind, m_result_kind);
                        fail_count++;
                    end
                    if (m_shown_value !== want.value) begin
                        $display("%0t: shown_value expected %h actual %h",
                                 $realtime, want.value, m_shown_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
